// ===== hw/rtl/text_console_writer_top_macros.svh =====
// Assertion macros used by the console back end.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  // Input item modes.
  typedef enum logic [1:0] {
    MODE_PUT        = 2'd0,
    MODE_CLEAR      = 2'd1,
    MODE_SET_CURSOR = 2'd2,
    MODE_READ       = 2'd3
  } mode_e;

  // Multi-cycle work that the back end carries out after an optional cell write.
  typedef enum logic [1:0] {
    SWEEP_NONE   = 2'd0,
    SWEEP_CLEAR  = 2'd1,
    SWEEP_SCROLL = 2'd2
  } sweep_e;

  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam int unsigned TAB_STOP   = 8;

  localparam logic [15:0] RESET_CELL = 16'h0720;

  // The grid never exceeds 128 x 32 cells, so 12 bits address any cell.
  localparam int unsigned CELL_ADDR_W = 12;
  typedef logic [CELL_ADDR_W-1:0] cell_addr_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] char_code;
    logic [6:0] target_col;
    logic [4:0] target_row;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_item_t;

  // One classified command from the front end to the back end.
  typedef struct packed {
    sweep_e      sweep;
    logic        wr_en;
    cell_addr_t  wr_addr;
    logic [15:0] wr_data;
    logic        rd_en;
    cell_addr_t  rd_addr;
    logic [10:0] cursor_position;
    logic        scrolled;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_front.sv =====
`default_nettype none

module tcw_front #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        text_color_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tcw_pkg::in_item_t in_data_i,
  input  wire logic              queue_full_i,
  input  wire logic              init_done_i,
  output logic                   push_o,
  output tcw_pkg::cmd_t          cmd_o
);
  import tcw_pkg::*;

  localparam int ColW = $clog2(TEXT_COLUMNS);
  localparam int RowW = $clog2(TEXT_ROWS);

  logic [ColW-1:0] cursor_col_q, cursor_col_d;
  logic [RowW-1:0] cursor_row_q, cursor_row_d;
  logic [ColW:0]   tab_col;
  logic            next_line;
  logic            target_ok;

  assign in_ready_o = !queue_full_i && init_done_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign tab_col = ({1'b0, cursor_col_q} + (ColW+1)'(TAB_STOP))
                 & ~((ColW+1)'(TAB_STOP - 1));
  assign target_ok = (int'(in_data_i.target_col) < TEXT_COLUMNS)
                  && (int'(in_data_i.target_row) < TEXT_ROWS);

  always_comb begin
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    next_line    = 1'b0;
    cmd_o        = '0;
    cmd_o.sweep  = SWEEP_NONE;
    unique case (in_data_i.mode)
      MODE_PUT: begin
        priority if (in_data_i.char_code == CH_NEWLINE) begin
          next_line = 1'b1;
        end else if (in_data_i.char_code == CH_RETURN) begin
          cursor_col_d = '0;
        end else if (in_data_i.char_code == CH_TAB) begin
          if (tab_col >= (ColW+1)'(TEXT_COLUMNS)) begin
            next_line = 1'b1;
          end else begin
            cursor_col_d = tab_col[ColW-1:0];
          end
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = CELL_ADDR_W'(int'(cursor_row_q) * TEXT_COLUMNS
                                      + int'(cursor_col_q));
          cmd_o.wr_data = {text_color_i, in_data_i.char_code};
          if (({1'b0, cursor_col_q} + 1'b1) >= (ColW+1)'(TEXT_COLUMNS)) begin
            next_line = 1'b1;
          end else begin
            cursor_col_d = cursor_col_q + 1'b1;
          end
        end
        if (next_line) begin
          cursor_col_d = '0;
          if (({1'b0, cursor_row_q} + 1'b1) >= (RowW+1)'(TEXT_ROWS)) begin
            cmd_o.sweep    = SWEEP_SCROLL;
            cmd_o.scrolled = 1'b1;
            cursor_row_d   = RowW'(TEXT_ROWS - 1);
          end else begin
            cursor_row_d = cursor_row_q + 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        cmd_o.sweep  = SWEEP_CLEAR;
        cursor_col_d = '0;
        cursor_row_d = '0;
      end
      MODE_SET_CURSOR: begin
        if (target_ok) begin
          cursor_col_d = ColW'(in_data_i.target_col);
          cursor_row_d = RowW'(in_data_i.target_row);
        end
      end
      MODE_READ: begin
        cmd_o.rd_en   = target_ok;
        cmd_o.rd_addr = CELL_ADDR_W'(int'(in_data_i.target_row) * TEXT_COLUMNS
                                    + int'(in_data_i.target_col));
      end
      default: ;
    endcase
    cmd_o.cursor_position = 11'(int'(cursor_row_d) * TEXT_COLUMNS + int'(cursor_col_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= '0;
      cursor_row_q <= '0;
    end else if (push_o) begin
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_fifo.sv =====
`default_nettype none

module tcw_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tcw_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output tcw_pkg::cmd_t      data_o,
  output logic               empty_o
);
  import tcw_pkg::*;

  cmd_t                   entries_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign full_o  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_back.sv =====
`default_nettype none

module tcw_back #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         text_color_i,
  input  wire logic               cmd_valid_i,
  input  wire tcw_pkg::cmd_t      cmd_i,
  output logic                    cmd_pop_o,
  output logic                    init_done_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tcw_pkg::out_item_t      out_data_o
);
  import tcw_pkg::*;
  `include "text_console_writer_top_macros.svh"

  localparam int CellCount = TEXT_COLUMNS * TEXT_ROWS;
  localparam int CopyCount = CellCount - TEXT_COLUMNS;
  localparam int AddrW     = $clog2(CellCount);
  localparam int CntW      = $clog2(CellCount + 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  cmd_t            cmd_q, cmd_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic [15:0]      cell_mem [CellCount];
  logic [15:0]      rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata;
  logic [15:0]      blank;
  logic             slot_free;

  assign blank       = {text_color_i, CH_SPACE};
  assign slot_free   = !out_valid_q || out_ready_i;
  assign init_done_o = (state_q != ST_INIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = blank;
    mem_raddr   = '0;
    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(cnt_q);
        mem_wdata = RESET_CELL;
        if (cnt_q == CntW'(CellCount - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cnt_d     = '0;
          mem_we    = cmd_i.wr_en;
          mem_waddr = cmd_i.wr_addr[AddrW-1:0];
          mem_wdata = cmd_i.wr_data;
          mem_raddr = cmd_i.rd_addr[AddrW-1:0];
          unique case (cmd_i.sweep)
            SWEEP_CLEAR:  state_d = ST_CLEAR;
            SWEEP_SCROLL: state_d = ST_SCROLL;
            default: begin
              if (cmd_i.rd_en) begin
                state_d = ST_READ;
              end else begin
                out_valid_d           = 1'b1;
                out_d.cursor_position = cmd_i.cursor_position;
                out_d.cell_data       = '0;
                out_d.scrolled        = cmd_i.scrolled;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_d           = 1'b1;
        out_d.cursor_position = cmd_q.cursor_position;
        out_d.cell_data       = rdata_q;
        out_d.scrolled        = cmd_q.scrolled;
        state_d               = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(cnt_q);
        if (cnt_q == CntW'(CellCount - 1)) begin
          out_valid_d           = 1'b1;
          out_d.cursor_position = cmd_q.cursor_position;
          out_d.cell_data       = '0;
          out_d.scrolled        = cmd_q.scrolled;
          state_d               = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCROLL: begin
        // Reads run one cell ahead of writes: cell k+columns is read while
        // the cell read last cycle lands at k-1. The bottom row gets blanks.
        if (cnt_q < CntW'(CopyCount)) begin
          mem_raddr = AddrW'(cnt_q + CntW'(TEXT_COLUMNS));
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AddrW'(cnt_q - 1'b1);
          mem_wdata = (cnt_q <= CntW'(CopyCount)) ? rdata_q : blank;
        end
        if (cnt_q == CntW'(CellCount)) begin
          out_valid_d           = 1'b1;
          out_d.cursor_position = cmd_q.cursor_position;
          out_d.cell_data       = '0;
          out_d.scrolled        = cmd_q.scrolled;
          state_d               = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= cell_mem[mem_raddr];
  end

  `TCW_ASSERT(a_pop_needs_entry, cmd_pop_o |-> cmd_valid_i, "pop from an empty queue")
  `TCW_ASSERT(a_init_queue_empty, (state_q == ST_INIT) |-> !cmd_valid_i, "item queued during init")
  `TCW_ASSERT(a_sweep_no_output, (state_q == ST_CLEAR || state_q == ST_SCROLL) |-> !out_valid_q, "result pending during a sweep")
  `TCW_ASSERT(a_waddr_in_grid, mem_we |-> (int'(mem_waddr) < CellCount), "cell write outside the grid")

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer_top.sv =====
// Text-mode console: a grid of TEXT_COLUMNS x TEXT_ROWS cells (attribute in
// the high byte, character in the low byte) and a cursor. Every input transfer
// yields exactly one output transfer with the cursor position after the step.
// A front end classifies each item and tracks the cursor, a four-entry queue
// holds the classified commands, and a back end owns the cell memory, which
// has one write port and one read port. Non-scrolling puts, set cursor and
// out-of-range reads finish in the state that takes the command; an in-range
// read passes through a read state (registered memory read); clear and scroll
// sweep the grid one cell per cycle via the memory port, a scroll with reads
// running one cell ahead of writes. After reset the back end fills the grid
// with grey spaces in one pass, during which in_ready_o stays low; text_color
// can be written over the APB port at any time while the block is idle.

`default_nettype none

module text_console_writer_top #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input item channel.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tcw_pkg::in_item_t  in_data_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tcw_pkg::out_item_t      out_data_o,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import tcw_pkg::*;

  logic [7:0] text_color_q;
  logic       cfg_write;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  logic       init_done;
  cmd_t       front_cmd;
  cmd_t       queue_cmd;

  // The APB port has no wait states. Register i sits at byte address 4*i,
  // so bit 2 of paddr picks the register; only the first one exists.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= 8'd7;
    end else if (cfg_write && (paddr[2] == REG_TEXT_COLOR)) begin
      text_color_q <= pwdata[7:0];
    end
  end

  // Reads of an unmapped address return zero.
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color_q} : 32'd0;

  // The front end accepts a transfer whenever the queue has room and the
  // power-on fill of the grid has finished.
  tcw_front #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .init_done_i  (init_done),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  tcw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .data_o  (queue_cmd),
    .empty_o (queue_empty)
  );

  // The back end writes and reads cells, runs the clear and scroll sweeps,
  // and holds the result in an output register until it is transferred.
  tcw_back #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color_q),
    .cmd_valid_i  (!queue_empty),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (pop),
    .init_done_o  (init_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  import tcw_pkg::*;

  // The grid matches the parameters handed to the console instance below.
  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // A clear or a scroll sweeps the whole grid one cell per cycle. Before a color
  // write, the bench lets a settling time run out so that no blank fill is still in flight.
  localparam int SETTLE_CYCLES = 2 * CELLS + 50;

  // This is the length of the long receiver hold-off that backs the console up.
  localparam int HOLD_CYCLES = 400;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_writer_top #(
    .TEXT_COLUMNS (COLS),
    .TEXT_ROWS    (ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the console: the grid, the cursor and the text color.
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_cells [CELLS];
  int          shadow_row;
  int          shadow_col;
  logic [7:0]  shadow_color;

  // Commands still waiting to be offered, and the status that each accepted
  // command is expected to report, oldest first.
  in_item_t    cmd_backlog [$];
  out_item_t   expected_status [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int accepted_cnt  = 0;
  int result_cnt    = 0;
  int scroll_cnt    = 0;
  int read_cnt      = 0;
  int color_writes  = 0;
  int fail_cnt      = 0;
  int hold_at       = -1;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // The cursor moves to column 0 of the next row. Past the last row, the grid
  // shifts up one row, and the bottom row fills with spaces in the current color.
  // The function returns 1 when a scroll took place.
  function automatic bit shadow_next_line();
    shadow_col = 0;
    if (shadow_row == ROWS - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = {shadow_color, CH_SPACE};
      return 1'b1;
    end
    shadow_row++;
    return 1'b0;
  endfunction

  // The function applies one command to the shadow console. It returns the
  // status that the block has to report for that command.
  function automatic out_item_t console_step(input in_item_t cmd);
    out_item_t res;
    int        tcol;
    int        trow;
    bit        in_grid;
    res     = '0;
    tcol    = cmd.target_col;
    trow    = cmd.target_row;
    in_grid = (tcol < COLS) && (trow < ROWS);
    case (cmd.mode)
      MODE_PUT: begin
        if (cmd.char_code == CH_NEWLINE) begin
          res.scrolled = shadow_next_line();
        end else if (cmd.char_code == CH_RETURN) begin
          shadow_col = 0;
        end else if (cmd.char_code == CH_TAB) begin
          // Tab moves to the next tab stop. A tab stop at or past the row end
          // moves the cursor to the next line.
          shadow_col = (shadow_col / int'(TAB_STOP) + 1) * int'(TAB_STOP);
          if (shadow_col >= COLS) res.scrolled = shadow_next_line();
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = {shadow_color, cmd.char_code};
          shadow_col++;
          if (shadow_col >= COLS) res.scrolled = shadow_next_line();
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_color, CH_SPACE};
        shadow_row = 0;
        shadow_col = 0;
      end
      MODE_SET_CURSOR: begin
        // A position outside the grid leaves the cursor unchanged.
        if (in_grid) begin
          shadow_col = tcol;
          shadow_row = trow;
        end
      end
      default: begin
        // A read outside the grid returns zero.
        if (in_grid) res.cell_data = shadow_cells[trow * COLS + tcol];
      end
    endcase
    res.cursor_position = 11'(shadow_row * COLS + shadow_col);
    return res;
  endfunction

  function automatic in_item_t make_cmd(input mode_e m, input logic [7:0] ch,
                                        input logic [6:0] col, input logic [4:0] row);
    in_item_t it;
    it.mode       = m;
    it.char_code  = ch;
    it.target_col = col;
    it.target_row = row;
    return it;
  endfunction

  // The function builds one random command. Most commands are puts, with a good share of
  // line control. Cursor moves often land on the bottom row or the last column, so
  // scrolls and wraps come often. One command in a hundred clears the
  // screen, which keeps the long sweeps rare.
  function automatic in_item_t random_cmd();
    in_item_t it;
    int       pick;
    int       sub;
    it   = make_cmd(MODE_PUT, 8'($urandom), 7'($urandom), 5'($urandom));
    pick = $urandom_range(0, 999);
    sub  = $urandom_range(0, 99);
    if (pick < 600) begin
      if (sub < 12)      it.char_code = CH_NEWLINE;
      else if (sub < 20) it.char_code = CH_TAB;
      else if (sub < 25) it.char_code = CH_RETURN;
    end else if (pick < 990) begin
      it.mode = (pick < 720) ? MODE_SET_CURSOR : MODE_READ;
      if (sub < 75) begin
        it.target_row = ($urandom_range(0, 1) == 0) ? 5'(ROWS - 1) : 5'($urandom_range(0, ROWS - 1));
        it.target_col = ($urandom_range(0, 3) == 0) ? 7'(COLS - 1) : 7'($urandom_range(0, COLS - 1));
      end
    end else begin
      it.mode = MODE_CLEAR;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: this block offers backlog commands on the input channel. When a transfer
  // completes, the driver predicts the status for the accepted command. Valid
  // stays up with a steady payload until the block accepts the command.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_status.push_back(console_step(in_data_i));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= cmd_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // After a set number of accepted commands, the receiver holds off once for a long
  // stretch. The sender keeps offering commands, so the queue inside the
  // block fills, and the input side has to stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_done && hold_at >= 0 && accepted_cnt >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: ready is driven at the rising edge. The check runs at the falling
  // edge just before the rising edge that completes the transfer. Between those
  // edges nothing moves, so the check never races the driver's prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(negedge clk_i) begin : check_status
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status.size() == 0) begin
        $error("result %0d arrived with no command outstanding", result_cnt);
        fail_cnt++;
      end else begin
        want = expected_status.pop_front();
        if (out_data_o.cursor_position !== want.cursor_position) begin
          $error("result %0d cursor_position: expected %0d, actual %0d", result_cnt,
                 want.cursor_position, out_data_o.cursor_position);
          fail_cnt++;
        end
        if (out_data_o.cell_data !== want.cell_data) begin
          $error("result %0d cell_data: expected 0x%04h, actual 0x%04h", result_cnt,
                 want.cell_data, out_data_o.cell_data);
          fail_cnt++;
        end
        if (out_data_o.scrolled !== want.scrolled) begin
          $error("result %0d scrolled: expected %0b, actual %0b", result_cnt,
                 want.scrolled, out_data_o.scrolled);
          fail_cnt++;
        end
        if (want.scrolled) scroll_cnt++;
        if (want.cell_data != 16'h0000) read_cnt++;
      end
      result_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing.
  // ---------------------------------------------------------------------------

  // The task waits until every command has been offered, accepted and answered. It then lets
  // any trailing grid sweep finish before it returns.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // An APB write to the text color register goes through a setup phase and an access phase. The register
  // takes the new value at the edge where the access phase sees pready.
  task automatic write_text_color(input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TEXT_COLOR, 2'b00};
    pwdata  <= {24'h000000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_color = value;
    color_writes++;
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct,
                            input bit with_hold);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (with_hold) hold_at = accepted_cnt + 100;
    repeat (count) cmd_backlog.push_back(random_cmd());
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = RESET_CELL;
    shadow_row   = 0;
    shadow_col   = 0;
    shadow_color = 8'h07;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The directed part runs with the reset color. It covers the grid's corners
    // and the reads outside the grid. It also covers every line control
    // character, the wrap at the row end, and the tab that crosses the row end.
    // Cursor moves outside the grid, scrolls caused by a plain character, a newline
    // and a tab, and a clear follow.
    @(negedge clk_i);
    send_idle_pct = 36;
    recv_idle_pct = 74;
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'h00, 7'd0,        5'd0));
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'hFF, 7'(COLS - 1), 5'(ROWS - 1)));
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'hFF, 7'd127,      5'd31));
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'h00, 7'(COLS),    5'd0));
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'h00, 7'd0,        5'(ROWS)));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        8'h41, 7'd127,      5'd31));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        8'h00, 7'd0,        5'd0));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        8'hFF, 7'd0,        5'd0));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        CH_TAB,     7'd0,   5'd0));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        CH_RETURN,  7'd0,   5'd0));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        CH_NEWLINE, 7'd0,   5'd0));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'h00, 7'(COLS - 1), 5'd0));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        8'h7E, 7'd0,        5'd0));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'h00, 7'(COLS - 4), 5'd1));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        CH_TAB,     7'd0,   5'd0));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'hFF, 7'd127,      5'd31));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'h00, 7'(COLS),    5'd0));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'h00, 7'd0,        5'(ROWS)));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'h00, 7'(COLS - 1), 5'(ROWS - 1)));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        8'h5A, 7'd0,        5'd0));
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'h00, 7'(COLS - 1), 5'(ROWS - 2)));
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'h00, 7'd0,        5'(ROWS - 1)));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'h00, 7'd5,        5'(ROWS - 1)));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        CH_NEWLINE, 7'd0,   5'd0));
    cmd_backlog.push_back(make_cmd(MODE_SET_CURSOR, 8'h00, 7'(COLS - 8), 5'(ROWS - 1)));
    cmd_backlog.push_back(make_cmd(MODE_PUT,        CH_TAB,     7'd0,   5'd0));
    cmd_backlog.push_back(make_cmd(MODE_CLEAR,      8'h00, 7'd0,        5'd0));
    cmd_backlog.push_back(make_cmd(MODE_READ,       8'h00, 7'd10,       5'd10));
    wait_idle();

    // The random part has three phases under different text colors. In the first, the sender idles
    // less than the receiver, and in the second it idles more. Neither side idles in the last
    // phase, which also holds the receiver off for a long stretch.
    write_text_color(8'h00);
    run_random(420, 36, 74, 1'b0);
    write_text_color(8'hFF);
    run_random(420, 74, 36, 1'b0);
    write_text_color(8'($urandom));
    run_random(410, 0, 0, 1'b1);

    $display("Ran %0d commands through the console and got %0d status transfers back.",
             accepted_cnt, result_cnt);
    $display("The status covered %0d scrolls and %0d nonzero cell reads under %0d text colors.",
             scroll_cnt, read_cnt, color_writes + 1);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // A watchdog ends a run that hangs. It allows more time than the slowest correct
  // run, in which every command would sweep the whole grid.
  initial begin
    #(20 * 10_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_fifo.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_top.sv
tb/testbench.sv
